// File: rtl/sfp_pkg.sv
// Package for the snapshot frame parser: field classes, phase codes, error codes,
// the parser state and result types, and the fixed field length table.
// Depends on nothing; used by sfp_step and snapshot_frame_parser.
package sfp_pkg;

   localparam logic [31:0] SNAP_MAGIC  = 32'h484F5453;
   localparam logic [31:0] SNAP_FORMAT = 32'd1;

   // Phases double as field classes.
   localparam logic [3:0] PH_MAGIC   = 4'd0;
   localparam logic [3:0] PH_FMTVER  = 4'd1;
   localparam logic [3:0] PH_SNAPVER = 4'd2;
   localparam logic [3:0] PH_NAMELEN = 4'd3;
   localparam logic [3:0] PH_NAME    = 4'd4;
   localparam logic [3:0] PH_DATALEN = 4'd5;
   localparam logic [3:0] PH_DATA    = 4'd6;
   localparam logic [3:0] PH_COUNT   = 4'd7;
   localparam logic [3:0] PH_KEYLEN  = 4'd8;
   localparam logic [3:0] PH_KEY     = 4'd9;
   localparam logic [3:0] PH_VALLEN  = 4'd10;
   localparam logic [3:0] PH_VAL     = 4'd11;
   localparam logic [3:0] PH_DONE    = 4'd12;
   localparam logic [3:0] CLASS_ERROR = 4'd13;
   localparam logic [3:0] WHERE_NONE  = 4'd12;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_PARSE   = 2'd1;
   localparam logic [1:0] ERR_VERSION = 2'd2;
   localparam logic [1:0] ERR_SHORT   = 2'd3;

   localparam logic [2:0] ST_BUSY    = 3'd0;
   localparam logic [2:0] ST_OK      = 3'd1;
   localparam logic [2:0] ST_PARSE   = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_SHORT   = 3'd4;

   localparam logic [3:0] SHORT_LIMIT = 4'd8;

   typedef struct packed {
      logic [3:0]  phase;
      logic [2:0]  length_byte_index;
      logic [63:0] word_shift;
      logic [63:0] bytes_left;
      logic [31:0] entries_left;
      logic [31:0] entries_count;
      logic [63:0] version_hold;
      logic [3:0]  total_seen;
      logic [1:0]  error_latch;
      logic [3:0]  error_where;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:             PH_MAGIC,
      length_byte_index: 3'd0,
      word_shift:        64'd0,
      bytes_left:        64'd0,
      entries_left:      32'd0,
      entries_count:     32'd0,
      version_hold:      64'd0,
      total_seen:        4'd0,
      error_latch:       ERR_NONE,
      error_where:       WHERE_NONE
   };

   typedef struct packed {
      logic [3:0]  field_class;
      logic [7:0]  field_byte;
      logic        last_of_field;
      logic [2:0]  parse_status;
      logic [3:0]  error_field;
      logic [63:0] snapshot_version;
      logic [31:0] entries_done;
   } result_type;

   // Bytes in each fixed-size field; zero marks a variable-length body.
   function automatic logic [3:0] fixed_len(input logic [3:0] ph);
      logic [3:0] len;
      case (ph)
         PH_MAGIC, PH_FMTVER, PH_NAMELEN, PH_COUNT, PH_KEYLEN, PH_VALLEN: len = 4'd4;
         PH_SNAPVER, PH_DATALEN: len = 4'd8;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/sfp_step.sv
// Combinational next-state and result logic for one byte of the snapshot parser.
// Depends on sfp_pkg for the state and result types and the field codes.
module sfp_step (
   input  sfp_pkg::state_type  state_cur,
   input  logic [7:0]          in_byte,
   input  logic                end_of_buffer,
   output sfp_pkg::state_type  state_nxt,
   output sfp_pkg::result_type result
);
   import sfp_pkg::*;

   state_type   nx;
   logic [3:0]  ph;
   logic [3:0]  cls;
   logic        last;
   logic [3:0]  flen;
   logic [2:0]  idx_inc;
   logic [63:0] word;
   logic [31:0] w32;
   logic [31:0] left_dec;
   logic [2:0]  status;

   assign left_dec = state_cur.entries_left - 32'd1;

   always_comb begin
      nx      = state_cur;
      ph      = (state_cur.phase > PH_DONE) ? PH_DONE : state_cur.phase;
      nx.phase = ph;
      cls     = ph;
      last    = 1'b0;
      flen    = fixed_len(ph);
      idx_inc = state_cur.length_byte_index + 3'd1;
      word    = state_cur.word_shift
                | ({56'd0, in_byte} << {state_cur.length_byte_index, 3'b000});
      w32     = word[31:0];
      status  = ST_BUSY;

      if (state_cur.total_seen < SHORT_LIMIT) begin
         nx.total_seen = state_cur.total_seen + 4'd1;
      end

      if (state_cur.error_latch != ERR_NONE) begin
         cls = CLASS_ERROR;
      end else if (ph == PH_DONE) begin
         cls = PH_DONE;
      end else if (flen != 4'd0) begin
         nx.length_byte_index = idx_inc;
         nx.word_shift        = word;
         if (idx_inc == flen[2:0]) begin
            last                 = 1'b1;
            nx.length_byte_index = 3'd0;
            nx.word_shift        = 64'd0;
            case (ph)
               PH_MAGIC: begin
                  if (w32 != SNAP_MAGIC) begin
                     nx.error_latch = ERR_PARSE;
                     nx.error_where = PH_MAGIC;
                  end else begin
                     nx.phase = PH_FMTVER;
                  end
               end
               PH_FMTVER: begin
                  if (w32 != SNAP_FORMAT) begin
                     nx.error_latch = ERR_VERSION;
                     nx.error_where = PH_FMTVER;
                  end else begin
                     nx.phase = PH_SNAPVER;
                  end
               end
               PH_SNAPVER: begin
                  nx.version_hold = word;
                  nx.phase        = PH_NAMELEN;
               end
               PH_NAMELEN: begin
                  nx.bytes_left = {32'd0, w32};
                  nx.phase      = (w32 != 32'd0) ? PH_NAME : PH_DATALEN;
               end
               PH_DATALEN: begin
                  nx.bytes_left = word;
                  nx.phase      = (word != 64'd0) ? PH_DATA : PH_COUNT;
               end
               PH_COUNT: begin
                  nx.entries_left = w32;
                  nx.phase        = (w32 != 32'd0) ? PH_KEYLEN : PH_DONE;
               end
               PH_KEYLEN: begin
                  nx.bytes_left = {32'd0, w32};
                  nx.phase      = (w32 != 32'd0) ? PH_KEY : PH_VALLEN;
               end
               default: begin
                  // Value length: an empty value closes the entry right here.
                  if (w32 != 32'd0) begin
                     nx.bytes_left = {32'd0, w32};
                     nx.phase      = PH_VAL;
                  end else begin
                     nx.entries_count = state_cur.entries_count + 32'd1;
                     nx.entries_left  = left_dec;
                     nx.phase         = (left_dec != 32'd0) ? PH_KEYLEN : PH_DONE;
                  end
               end
            endcase
         end
      end else begin
         if (state_cur.bytes_left <= 64'd1) begin
            nx.bytes_left = 64'd0;
            last          = 1'b1;
            case (ph)
               PH_NAME: nx.phase = PH_DATALEN;
               PH_DATA: nx.phase = PH_COUNT;
               PH_KEY:  nx.phase = PH_VALLEN;
               default: begin
                  nx.entries_count = state_cur.entries_count + 32'd1;
                  nx.entries_left  = left_dec;
                  nx.phase         = (left_dec != 32'd0) ? PH_KEYLEN : PH_DONE;
               end
            endcase
         end else begin
            nx.bytes_left = state_cur.bytes_left - 64'd1;
         end
      end

      if (end_of_buffer) begin
         if (nx.total_seen < SHORT_LIMIT) begin
            nx.error_latch = ERR_SHORT;
            nx.error_where = WHERE_NONE;
         end else if (nx.error_latch == ERR_NONE && nx.phase != PH_DONE) begin
            nx.error_latch = ERR_PARSE;
            nx.error_where = nx.phase;
         end
      end

      if (nx.error_latch != ERR_NONE) begin
         status = {1'b0, nx.error_latch} + 3'd1;
      end else if (nx.phase == PH_DONE) begin
         status = ST_OK;
      end

      result.field_class      = cls;
      result.field_byte       = in_byte;
      result.last_of_field    = last;
      result.parse_status     = status;
      result.error_field      = nx.error_where;
      result.snapshot_version = nx.version_hold;
      result.entries_done     = nx.entries_count;

      state_nxt = end_of_buffer ? STATE_RESET : nx;
   end

endmodule

// File: rtl/snapshot_frame_parser.sv
// Top level of the snapshot frame parser: input register, parser state,
// result register and handshake control. Depends on sfp_pkg and sfp_step.
//
// The snapshot buffer arrives on the req_ channel one byte per item, with
// req_tlast set on its final byte. Every accepted item yields exactly one
// result item on the rsp_ channel, in order. rsp_tuser carries the field
// class of the byte; rsp_tlast marks the byte that completes its field;
// rsp_tdata carries the echoed byte, the parse status, the field where the
// first error arose, the decoded snapshot version and the count of metadata
// entries parsed so far.
// A result is shown once its item has left the input register: the item
// waits in the input register, and when it advances the parser state and
// the result register update together. Throughput is one item per cycle
// while the receiver does not stall; the parser state loop runs through sfp_step.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; after that req_tready drops until the
// result is taken. Synchronous reset empties both registers and returns the
// parser to the start of a buffer. The result of the flagged final byte
// shows the final status, and the parser then starts the next buffer fresh.
module snapshot_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] in_byte
   input  logic         req_tlast,   // end_of_buffer
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // [7:0] field_byte, [10:8] parse_status,
                                     // [14:11] error_field,
                                     // [78:15] snapshot_version,
                                     // [110:79] entries_done, [111] zero
   output logic [3:0]   rsp_tuser,   // [3:0] field_class
   output logic         rsp_tlast    // last_of_field
);
   import sfp_pkg::*;

   // Input register.
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parser state and result register.
   state_type  state_ff;
   state_type  state_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type step_res;

   logic       advance;
   logic       req_take;

   // An item moves from the input register to the result register when the
   // result register is empty or its item is being taken in this cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   sfp_step u_step (
      .state_cur     (state_ff),
      .in_byte       (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .state_nxt     (state_in),
      .result        (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.field_class;
   assign rsp_tlast  = out_res_ff.last_of_field;
   assign rsp_tdata  = {1'b0,
                        out_res_ff.entries_done,
                        out_res_ff.snapshot_version,
                        out_res_ff.error_field,
                        out_res_ff.parse_status,
                        out_res_ff.field_byte};

   // An error-class byte always reports one of the error statuses.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CLASS_ERROR |->
         rsp_tdata[10:8] == ST_PARSE || rsp_tdata[10:8] == ST_VERSION
         || rsp_tdata[10:8] == ST_SHORT)
      else $error("error-class byte without an error status");

   // Trailing and error bytes never close a field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser != PH_DONE && rsp_tuser != CLASS_ERROR)
      else $error("trailing or error byte marked as last of field");

   // A too-short buffer reports no error field.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] == ST_SHORT |-> rsp_tdata[14:11] == WHERE_NONE)
      else $error("too-short status with an error field");

   // The final byte of a buffer returns the parser to its start.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=>
         state_ff.phase == PH_MAGIC && state_ff.total_seen == 4'd0
         && state_ff.error_latch == ERR_NONE)
      else $error("parser state not cleared after the final byte");

endmodule
